/* src/wsie_pkg.sv */
// ----------------------------------------------------------------------------
// wsie_pkg: shared types and constants for the security IE parser
// Element codes, suite selector decoding, walker state layout and result.
// ----------------------------------------------------------------------------
package wsie_pkg;

  localparam logic [7:0]  KIND_RSN    = 8'd48;
  localparam logic [7:0]  KIND_VENDOR = 8'd221;
  localparam logic [23:0] OUI_MASK    = 24'hFF_FFFF;
  localparam logic [23:0] SUITE_OUI   = 24'hAC_0F00;
  localparam logic [31:0] WPA_TAG     = 32'h01F2_5000;
  localparam logic [31:0] VERSION_ONE = 32'd1;

  localparam logic [5:0] C_NONE   = 6'h01;
  localparam logic [5:0] C_WEP40  = 6'h02;
  localparam logic [5:0] C_WEP104 = 6'h04;
  localparam logic [5:0] C_TKIP   = 6'h08;
  localparam logic [5:0] C_CCMP   = 6'h10;
  localparam logic [5:0] C_CMAC   = 6'h20;

  localparam logic [5:0] K_8021X        = 6'h01;
  localparam logic [5:0] K_PSK          = 6'h02;
  localparam logic [5:0] K_FT8021X      = 6'h04;
  localparam logic [5:0] K_FTPSK        = 6'h08;
  localparam logic [5:0] K_8021X_SHA256 = 6'h10;
  localparam logic [5:0] K_PSK_SHA256   = 6'h20;

  localparam logic [1:0] AUTH_NONE = 2'd0;
  localparam logic [1:0] AUTH_WPA  = 2'd2;
  localparam logic [1:0] AUTH_WPA2 = 2'd3;

  // cipher selectors
  localparam logic [7:0] SEL_C_NONE   = 8'd0;
  localparam logic [7:0] SEL_C_WEP40  = 8'd1;
  localparam logic [7:0] SEL_C_TKIP   = 8'd2;
  localparam logic [7:0] SEL_C_CMAC   = 8'd3;
  localparam logic [7:0] SEL_C_WEP104 = 8'd5;
  // key management selectors
  localparam logic [7:0] SEL_K_PSK          = 8'd2;
  localparam logic [7:0] SEL_K_FT8021X      = 8'd3;
  localparam logic [7:0] SEL_K_FTPSK        = 8'd4;
  localparam logic [7:0] SEL_K_8021X_SHA256 = 8'd5;
  localparam logic [7:0] SEL_K_PSK_SHA256   = 8'd6;

  typedef enum logic [2:0] {
    PH_TYPE = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef enum logic [8:0] {
    STEP_VER    = 9'b000000001,
    STEP_GROUP  = 9'b000000010,
    STEP_PCNT   = 9'b000000100,
    STEP_PSUITE = 9'b000001000,
    STEP_KCNT   = 9'b000010000,
    STEP_KSUITE = 9'b000100000,
    STEP_DONE   = 9'b001000000,
    STEP_WOUI   = 9'b010000000,
    STEP_WVER   = 9'b100000000
  } step_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  kind;
    logic [7:0]  left;
    step_t       step;
    logic [23:0] shift;
    logic [1:0]  fbyte;
    logic [15:0] cnt;
    logic        stopped;
    logic [1:0]  auth_acc;
    logic [5:0]  cipher_acc;
    logic [5:0]  group_acc;
    logic [5:0]  key_acc;
    logic        rsn_seen;
    logic        wpa_seen;
  } wsie_state_t;

  localparam wsie_state_t WALK_RESET = '{
    phase:      PH_TYPE,
    kind:       8'd0,
    left:       8'd0,
    step:       STEP_VER,
    shift:      24'd0,
    fbyte:      2'd0,
    cnt:        16'd0,
    stopped:    1'b0,
    auth_acc:   AUTH_NONE,
    cipher_acc: 6'd0,
    group_acc:  6'd0,
    key_acc:    6'd0,
    rsn_seen:   1'b0,
    wpa_seen:   1'b0
  };

  typedef struct packed {
    logic [1:0] auth_mode;
    logic [5:0] cipher_mask;
    logic [5:0] group_cipher_mask;
    logic [5:0] key_mode_mask;
    logic       had_rsn;
    logic       had_wpa;
  } wsie_result_t;

  function automatic logic [5:0] cipher_bit(input logic [31:0] v);
    logic [5:0] r;
    r = C_CCMP;
    if ((v[23:0] & OUI_MASK) == SUITE_OUI) begin
      unique case (v[31:24])
        SEL_C_NONE:   r = C_NONE;
        SEL_C_WEP40:  r = C_WEP40;
        SEL_C_TKIP:   r = C_TKIP;
        SEL_C_CMAC:   r = C_CMAC;
        SEL_C_WEP104: r = C_WEP104;
        default:      r = C_CCMP;
      endcase
    end
    return r;
  endfunction

  function automatic logic [5:0] key_bit(input logic [31:0] v);
    logic [5:0] r;
    r = K_8021X;
    if ((v[23:0] & OUI_MASK) == SUITE_OUI) begin
      unique case (v[31:24])
        SEL_K_PSK:          r = K_PSK;
        SEL_K_FT8021X:      r = K_FT8021X;
        SEL_K_FTPSK:        r = K_FTPSK;
        SEL_K_8021X_SHA256: r = K_8021X_SHA256;
        SEL_K_PSK_SHA256:   r = K_PSK_SHA256;
        default:            r = K_8021X;
      endcase
    end
    return r;
  endfunction

  // bytes in the field read at this step, zero when nothing is read
  function automatic logic [2:0] field_need(input step_t s);
    logic [2:0] r;
    unique case (s)
      STEP_VER, STEP_PCNT, STEP_KCNT, STEP_WVER:       r = 3'd2;
      STEP_GROUP, STEP_PSUITE, STEP_KSUITE, STEP_WOUI: r = 3'd4;
      default:                                         r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/wsie_in_if.sv */
// ----------------------------------------------------------------------------
// wsie_in_if: byte request channel of the security IE parser
// One byte of the element list per request, with a last-byte mark.
// ----------------------------------------------------------------------------
interface wsie_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

/* src/wsie_out_if.sv */
// ----------------------------------------------------------------------------
// wsie_out_if: result channel of the security IE parser
// One request per element list: authentication mode and suite masks.
// ----------------------------------------------------------------------------
interface wsie_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] auth_mode;
  logic [5:0] cipher_mask;
  logic [5:0] group_cipher_mask;
  logic [5:0] key_mode_mask;
  logic       had_rsn;
  logic       had_wpa;

  modport source (output valid, output auth_mode, output cipher_mask,
                  output group_cipher_mask, output key_mode_mask,
                  output had_rsn, output had_wpa, input ready);
  modport sink   (input valid, input auth_mode, input cipher_mask,
                  input group_cipher_mask, input key_mode_mask,
                  input had_rsn, input had_wpa, output ready);
endinterface

/* src/wsie_walker.sv */
// ----------------------------------------------------------------------------
// wsie_walker: type/length/body walker with RSN and WPA field decoding
// Holds the parse state and advances it by one byte per enabled cycle.
// ----------------------------------------------------------------------------
module wsie_walker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step_en,
  input  logic [7:0]           data_byte,
  input  logic                 last,
  output wsie_pkg::wsie_result_t result
);
  import wsie_pkg::*;

  wsie_state_t st;
  wsie_state_t st_next;
  wsie_state_t upd;
  logic [2:0]  need;
  logic [31:0] word;

  always_comb begin
    upd  = st;
    need = field_need(st.step);
    word = (need == 3'd4) ? {data_byte, st.shift} : {16'd0, data_byte, st.shift[7:0]};

    unique case (st.phase)
      PH_TYPE: begin
        upd.kind  = data_byte;
        upd.phase = PH_LEN;
      end
      PH_LEN: begin
        upd.left    = data_byte;
        upd.stopped = 1'b0;
        upd.fbyte   = 2'd0;
        upd.shift   = 24'd0;
        upd.cnt     = 16'd0;
        if (st.kind == KIND_RSN) begin
          upd.auth_acc   = AUTH_WPA2;
          upd.cipher_acc = C_CCMP;
          upd.group_acc  = C_CCMP;
          upd.key_acc    = K_8021X;
          upd.rsn_seen   = 1'b1;
          upd.step       = STEP_VER;
          upd.stopped    = (data_byte < 8'd2);
        end else if (st.kind == KIND_VENDOR && !st.rsn_seen && data_byte >= 8'd6) begin
          upd.step = STEP_WOUI;
        end else begin
          upd.step    = STEP_DONE;
          upd.stopped = 1'b1;
        end
        upd.phase = (data_byte != 8'd0) ? PH_BODY : PH_TYPE;
      end
      PH_BODY: begin
        if (!st.stopped && need != 3'd0) begin
          if (st.fbyte == 2'd0 && st.left < {5'd0, need}) begin
            // field runs past the declared length: ignore rest of element
            upd.stopped = 1'b1;
          end else if ({1'b0, st.fbyte} == need - 3'd1) begin
            upd.fbyte = 2'd0;
            unique case (st.step)
              STEP_VER: begin
                if (word != VERSION_ONE) upd.stopped = 1'b1;
                else                     upd.step    = STEP_GROUP;
              end
              STEP_WOUI: begin
                if (word != WPA_TAG) upd.stopped = 1'b1;
                else                 upd.step    = STEP_WVER;
              end
              STEP_WVER: begin
                if (word != VERSION_ONE) begin
                  upd.stopped = 1'b1;
                end else begin
                  upd.auth_acc   = AUTH_WPA;
                  upd.cipher_acc = C_TKIP;
                  upd.group_acc  = C_TKIP;
                  upd.key_acc    = K_8021X;
                  upd.wpa_seen   = 1'b1;
                  upd.step       = STEP_GROUP;
                end
              end
              STEP_GROUP: begin
                upd.group_acc = cipher_bit(word);
                upd.step      = STEP_PCNT;
              end
              STEP_PCNT: begin
                upd.cnt        = word[15:0];
                upd.cipher_acc = 6'd0;
                upd.step       = (word[15:0] != 16'd0) ? STEP_PSUITE : STEP_KCNT;
              end
              STEP_PSUITE: begin
                upd.cipher_acc = st.cipher_acc | cipher_bit(word);
                upd.cnt        = st.cnt - 16'd1;
                if (upd.cnt == 16'd0) upd.step = STEP_KCNT;
              end
              STEP_KCNT: begin
                upd.cnt     = word[15:0];
                upd.key_acc = 6'd0;
                upd.step    = (word[15:0] != 16'd0) ? STEP_KSUITE : STEP_DONE;
              end
              STEP_KSUITE: begin
                upd.key_acc = st.key_acc | key_bit(word);
                upd.cnt     = st.cnt - 16'd1;
                if (upd.cnt == 16'd0) upd.step = STEP_DONE;
              end
              default: ;
            endcase
          end else begin
            // hold the low bytes of a field until its final byte arrives
            unique case (st.fbyte)
              2'd0:    upd.shift[7:0]   = data_byte;
              2'd1:    upd.shift[15:8]  = data_byte;
              2'd2:    upd.shift[23:16] = data_byte;
              default: upd.shift        = st.shift;
            endcase
            upd.fbyte = st.fbyte + 2'd1;
          end
        end
        upd.left = st.left - 8'd1;
        if (upd.left == 8'd0) upd.phase = PH_TYPE;
      end
      default: upd.phase = PH_TYPE;
    endcase

    result.auth_mode = upd.auth_acc;
    if (upd.rsn_seen || upd.wpa_seen) begin
      if ((upd.key_acc & (K_8021X_SHA256 | K_PSK_SHA256)) != 6'd0) begin
        result.auth_mode = AUTH_WPA2;
      end else if ((upd.key_acc & (K_8021X | K_PSK | K_FT8021X | K_FTPSK)) != 6'd0
                   && !upd.rsn_seen) begin
        result.auth_mode = AUTH_WPA;
      end
    end
    result.cipher_mask       = upd.cipher_acc;
    result.group_cipher_mask = upd.group_acc;
    result.key_mode_mask     = upd.key_acc;
    result.had_rsn           = upd.rsn_seen;
    result.had_wpa           = upd.wpa_seen;

    // drop all state after the final byte of a list
    st_next = last ? WALK_RESET : upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= WALK_RESET;
    end else if (step_en) begin
      st <= st_next;
    end
  end

`ifndef ASSERT_OFF
  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    step_en && last |=> st.phase == PH_TYPE && !st.rsn_seen && !st.wpa_seen)
    else $error("walker state not cleared after last byte");

  a_fbyte_clear_between: assert property (@(posedge clk) disable iff (rst)
    st.phase != PH_BODY |-> st.fbyte == 2'd0)
    else $error("partial field left open outside an element body");

  a_count_in_list: assert property (@(posedge clk) disable iff (rst)
    st.cnt != 16'd0 |-> st.step == STEP_PSUITE || st.step == STEP_KSUITE)
    else $error("suite count live outside a suite list");
`endif

endmodule

/* src/wifi_security_ie_parser_core.sv */
// ----------------------------------------------------------------------------
// wifi_security_ie_parser_core: 802.11 RSN/WPA information element parser
// Walks an IE list byte by byte and reports the security configuration.
//
//   channel  dir  payload                                        requests
//   ie_in    in   data_byte[7:0], last                           one per byte
//   sec_out  out  auth_mode, cipher_mask, group_cipher_mask,     one per list
//                 key_mode_mask, had_rsn, had_wpa
//
// The walker takes one byte per cycle, except while a last byte is stalled.
// Result valid rises after the last byte is accepted: the byte lands in the
// input register, and the walker update then lands in the result register.
// A byte is stalled only when it is the last byte of a list and the result
// register still holds an untaken result.
// Synchronous reset clears the walker to awaiting an element type byte.
// ----------------------------------------------------------------------------
module wifi_security_ie_parser_core (
  input logic      clk,
  input logic      rst,
  wsie_in_if.sink  ie_in,
  wsie_out_if.source sec_out
);
  import wsie_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         out_valid;
  logic         adv;
  wsie_result_t walk_result;
  wsie_result_t result_q;

  assign adv          = in_valid_q && (!in_last_q || !out_valid || sec_out.ready);
  assign ie_in.ready  = !in_valid_q || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (ie_in.ready) begin
      in_valid_q <= ie_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ie_in.valid && ie_in.ready) begin
      in_byte_q <= ie_in.data_byte;
      in_last_q <= ie_in.last;
    end
  end

  wsie_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .step_en   (adv),
    .data_byte (in_byte_q),
    .last      (in_last_q),
    .result    (walk_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && in_last_q) begin
      out_valid <= 1'b1;
    end else if (sec_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_q) begin
      result_q <= walk_result;
    end
  end

  assign sec_out.valid             = out_valid;
  assign sec_out.auth_mode         = result_q.auth_mode;
  assign sec_out.cipher_mask       = result_q.cipher_mask;
  assign sec_out.group_cipher_mask = result_q.group_cipher_mask;
  assign sec_out.key_mode_mask     = result_q.key_mode_mask;
  assign sec_out.had_rsn           = result_q.had_rsn;
  assign sec_out.had_wpa           = result_q.had_wpa;

`ifndef ASSERT_OFF
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(adv && in_last_q))
    else $error("result raised without a last byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    adv && in_last_q |=> out_valid)
    else $error("last byte processed but no result presented");

  a_wpa2_needs_element: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_q.auth_mode == AUTH_WPA2 |-> result_q.had_rsn || result_q.had_wpa)
    else $error("wpa2 reported without a security element");
`endif

endmodule
